// ===== rtl/mqla_pkg.sv =====
package mqla_pkg;

  localparam int MAX_THREADS = 16;
  localparam int CPU_COUNT   = 8;
  localparam int THREAD_W    = $clog2(MAX_THREADS);
  localparam int CPU_W       = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int TICKET_W    = 32;
  localparam int SLICE_W     = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [SLICE_W-1:0]   SLICE_RESET = 16'd3000;
  localparam logic [SLICE_W-1:0]   WAKE_RESET  = 16'd3000;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE    = 1'b1;

  typedef logic [THREAD_W-1:0] thread_t;
  typedef logic [CPU_W-1:0]    cpu_t;

  typedef enum logic [1:0] {
    OP_LOCK   = 2'd0,
    OP_TICK   = 2'd1,
    OP_UNLOCK = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_ACTIVE = 2'd1,
    Q_SLEEP  = 2'd2
  } queue_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GRANTED  = 3'd1,
    EV_QACTIVE  = 3'd2,
    EV_QSEC     = 3'd3,
    EV_SLEPT    = 3'd4,
    EV_WOKE     = 3'd5,
    EV_HANDED   = 3'd6,
    EV_RELEASED = 3'd7
  } ev_t;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    cpu_t                cpu;
    logic [SLICE_W-1:0]  act_left;
    logic [SLICE_W-1:0]  slp_left;
  } entry_t;

endpackage

// ===== rtl/mqla_if.sv =====
interface mqla_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [3:0] thread_id;
  logic [2:0] cpu_id;
  modport source(output valid, output op, output thread_id, output cpu_id, input ready);
  modport sink(input valid, input op, input thread_id, input cpu_id, output ready);
endinterface

interface mqla_out_if;
  logic       valid;
  logic       ready;
  logic       owner_valid;
  logic [3:0] owner_thread;
  logic       thread_waiting;
  logic [2:0] event_res;
  modport source(output valid, output owner_valid, output owner_thread,
                 output thread_waiting, output event_res, input ready);
  modport sink(input valid, input owner_valid, input owner_thread,
               input thread_waiting, input event_res, output ready);
endinterface

// ===== rtl/mqla_ram.sv =====
module mqla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/multi_queue_lock_arbiter.sv =====
// Lock arbiter with one active queue (one flagged waiter per cpu) and a sleeping
// queue per cpu. Items are handled one at a time. Wait ticks for a waiting thread
// read the per-thread entry memory once or twice, and an unlock reads every thread
// entry through the single read port of the entry memory to find the oldest active
// waiter, or else a sleeping one (lowest cpu first). A result waits in an output
// register while the next item is accepted. Configuration writes are taken in any
// cycle.
module multi_queue_lock_arbiter (
  input  logic                              clk,
  input  logic                              rst_n,
  mqla_in_if.sink                           in_ch,
  mqla_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [mqla_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mqla_pkg::SLICE_W-1:0]      cfg_wdata
);

  import mqla_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_RD2, S_SCAN, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic [SLICE_W-1:0] slice_r, slice_nxt, wake_r, wake_nxt;
  logic owner_v_r, owner_v_nxt;
  thread_t owner_r, owner_nxt;
  logic [TICKET_W-1:0] ticket_r, ticket_nxt;
  queue_t queue_r [MAX_THREADS];
  queue_t queue_nxt [MAX_THREADS];
  logic [CPU_COUNT-1:0] cpu_v_r, cpu_v_nxt;
  thread_t cpu_t_r [CPU_COUNT];
  thread_t cpu_t_nxt [CPU_COUNT];

  thread_t tid_r, tid_nxt;
  logic tid_ok_r, tid_ok_nxt;
  ev_t ev_r, ev_nxt;
  entry_t ent_r, ent_nxt;
  logic [THREAD_W:0] cnt_r, cnt_nxt;
  logic pend_r, pend_nxt;
  thread_t pidx_r, pidx_nxt;
  logic af_r, af_nxt, sf_r, sf_nxt;
  thread_t aidx_r, aidx_nxt, sidx_r, sidx_nxt;
  logic [TICKET_W-1:0] aage_r, aage_nxt, sage_r, sage_nxt;
  cpu_t acpu_r, acpu_nxt, scpu_r, scpu_nxt;

  logic out_v_r, out_v_nxt;
  logic ow_r, ow_nxt, tw_r, tw_nxt;
  logic [3:0] ot_r, ot_nxt;
  logic [2:0] oe_r, oe_nxt;

  logic ram_we;
  thread_t ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;
  logic [$bits(entry_t)-1:0] ram_rbits;

  mqla_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_THREADS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata    = entry_t'(ram_rbits);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_v_r;
  assign out_ch.owner_valid    = ow_r;
  assign out_ch.owner_thread   = ot_r;
  assign out_ch.thread_waiting = tw_r;
  assign out_ch.event_res      = oe_r;

  always_comb begin
    entry_t e;
    thread_t ti;
    cpu_t ci;
    cpu_t c;
    logic [TICKET_W-1:0] age;
    queue_t q;
    state_nxt = state_r;
    slice_nxt = slice_r;
    wake_nxt = wake_r;
    owner_v_nxt = owner_v_r;
    owner_nxt = owner_r;
    ticket_nxt = ticket_r;
    queue_nxt = queue_r;
    cpu_v_nxt = cpu_v_r;
    cpu_t_nxt = cpu_t_r;
    tid_nxt = tid_r;
    tid_ok_nxt = tid_ok_r;
    ev_nxt = ev_r;
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    af_nxt = af_r;
    sf_nxt = sf_r;
    aidx_nxt = aidx_r;
    sidx_nxt = sidx_r;
    aage_nxt = aage_r;
    sage_nxt = sage_r;
    acpu_nxt = acpu_r;
    scpu_nxt = scpu_r;
    out_v_nxt = out_v_r && !out_ch.ready;
    ow_nxt = ow_r;
    ot_nxt = ot_r;
    tw_nxt = tw_r;
    oe_nxt = oe_r;
    ram_we = 1'b0;
    ram_waddr = tid_r;
    ram_raddr = tid_r;
    e = ram_rdata;
    ram_wdata = e;
    ti = in_ch.thread_id[THREAD_W-1:0];
    ci = in_ch.cpu_id[CPU_W-1:0];
    c = e.cpu;
    age = ticket_r - e.ticket;
    q = queue_r[pidx_r];

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SLICE: slice_nxt = cfg_wdata;
        CFG_WAKE:  wake_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          tid_nxt = ti;
          tid_ok_nxt = int'(in_ch.thread_id) < MAX_THREADS;
          ev_nxt = EV_NONE;
          state_nxt = S_DONE;
          unique case (op_t'(in_ch.op))
            OP_LOCK: begin
              if (tid_ok_nxt) begin
                if (!owner_v_r) begin
                  owner_v_nxt = 1'b1;
                  owner_nxt = ti;
                  ev_nxt = EV_GRANTED;
                end else if (queue_r[ti] == Q_NONE) begin
                  ticket_nxt = ticket_r + 1'b1;
                  ram_we = 1'b1;
                  ram_waddr = ti;
                  ram_wdata.ticket = ticket_nxt;
                  ram_wdata.cpu = ci;
                  if (cpu_v_r[ci]) begin
                    queue_nxt[ti] = Q_SLEEP;
                    ram_wdata.act_left = '0;
                    ram_wdata.slp_left = slice_r;
                    ev_nxt = EV_QSEC;
                  end else begin
                    queue_nxt[ti] = Q_ACTIVE;
                    ram_wdata.act_left = slice_r;
                    ram_wdata.slp_left = '0;
                    cpu_v_nxt[ci] = 1'b1;
                    cpu_t_nxt[ci] = ti;
                    ev_nxt = EV_QACTIVE;
                  end
                end
              end
            end
            OP_TICK: begin
              if (tid_ok_nxt && queue_r[ti] != Q_NONE) begin
                ram_raddr = ti;
                state_nxt = S_RD;
              end
            end
            OP_UNLOCK: begin
              cnt_nxt = '0;
              pend_nxt = 1'b0;
              af_nxt = 1'b0;
              sf_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            OP_QUERY: ;
            default: ;
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_DONE;
        if (queue_r[tid_r] == Q_ACTIVE) begin
          e.act_left = e.act_left - 1'b1;
          if (e.act_left == '0) begin
            queue_nxt[tid_r] = Q_SLEEP;
            e.slp_left = slice_r;
            if (cpu_v_r[c] && cpu_t_r[c] == tid_r) begin
              cpu_v_nxt[c] = 1'b0;
            end
            ev_nxt = EV_SLEPT;
          end
          ram_we = 1'b1;
        end else begin
          e.slp_left = e.slp_left - 1'b1;
          if (e.slp_left != '0) begin
            ram_we = 1'b1;
          end else if (!cpu_v_r[c]) begin
            queue_nxt[tid_r] = Q_ACTIVE;
            e.act_left = slice_r;
            cpu_v_nxt[c] = 1'b1;
            cpu_t_nxt[c] = tid_r;
            ev_nxt = EV_WOKE;
            ram_we = 1'b1;
          end else begin
            ent_nxt = e;
            ram_raddr = cpu_t_r[c];
            state_nxt = S_RD2;
          end
        end
        ram_wdata = e;
      end
      S_RD2: begin
        e = ent_r;
        c = ent_r.cpu;
        if (ram_rdata.act_left < wake_r) begin
          queue_nxt[tid_r] = Q_ACTIVE;
          e.act_left = slice_r;
          cpu_v_nxt[c] = 1'b1;
          cpu_t_nxt[c] = tid_r;
          ev_nxt = EV_WOKE;
        end else begin
          e.slp_left = slice_r;
        end
        ram_we = 1'b1;
        ram_wdata = e;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (pend_r) begin
          if (q == Q_ACTIVE && (!af_r || age > aage_r)) begin
            af_nxt = 1'b1;
            aidx_nxt = pidx_r;
            aage_nxt = age;
            acpu_nxt = e.cpu;
          end
          if (q == Q_SLEEP && (!sf_r || e.cpu < scpu_r ||
                               (e.cpu == scpu_r && age > sage_r))) begin
            sf_nxt = 1'b1;
            sidx_nxt = pidx_r;
            sage_nxt = age;
            scpu_nxt = e.cpu;
          end
        end
        if (cnt_r < (THREAD_W+1)'(MAX_THREADS)) begin
          ram_raddr = cnt_r[THREAD_W-1:0];
          pend_nxt = 1'b1;
          pidx_nxt = cnt_r[THREAD_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
            if (af_r || sf_r) begin
              if (af_r) begin
                cpu_v_nxt[acpu_r] = 1'b0;
              end
              queue_nxt[af_r ? aidx_r : sidx_r] = Q_NONE;
              owner_v_nxt = 1'b1;
              owner_nxt = af_r ? aidx_r : sidx_r;
              ev_nxt = EV_HANDED;
            end else if (owner_v_r) begin
              owner_v_nxt = 1'b0;
              owner_nxt = '0;
              ev_nxt = EV_RELEASED;
            end
          end
        end
      end
      S_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt = 1'b1;
          ow_nxt = owner_v_r;
          ot_nxt = 4'(owner_r);
          tw_nxt = tid_ok_r && queue_r[tid_r] != Q_NONE;
          oe_nxt = ev_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tid_r <= tid_nxt;
    tid_ok_r <= tid_ok_nxt;
    ev_r <= ev_nxt;
    ent_r <= ent_nxt;
    cnt_r <= cnt_nxt;
    pend_r <= pend_nxt;
    pidx_r <= pidx_nxt;
    af_r <= af_nxt;
    sf_r <= sf_nxt;
    aidx_r <= aidx_nxt;
    sidx_r <= sidx_nxt;
    aage_r <= aage_nxt;
    sage_r <= sage_nxt;
    acpu_r <= acpu_nxt;
    scpu_r <= scpu_nxt;
    cpu_t_r <= cpu_t_nxt;
    ow_r <= ow_nxt;
    ot_r <= ot_nxt;
    tw_r <= tw_nxt;
    oe_r <= oe_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      slice_r <= SLICE_RESET;
      wake_r <= WAKE_RESET;
      owner_v_r <= 1'b0;
      owner_r <= '0;
      ticket_r <= '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        queue_r[i] <= Q_NONE;
      end
      cpu_v_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slice_r <= slice_nxt;
      wake_r <= wake_nxt;
      owner_v_r <= owner_v_nxt;
      owner_r <= owner_nxt;
      ticket_r <= ticket_nxt;
      queue_r <= queue_nxt;
      cpu_v_r <= cpu_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

// ===== rtl/mqla_chk.sv =====
module mqla_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       owner_valid,
  input logic [3:0] owner_thread,
  input logic       thread_waiting,
  input logic [2:0] event_res
);

  import mqla_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !owner_valid |-> owner_thread == 4'd0) else $error("owner not cleared");

  a_owner_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((event_res == EV_RELEASED) ? !owner_valid :
                   ((event_res == EV_GRANTED || event_res == EV_HANDED ||
                     event_res == EV_QACTIVE || event_res == EV_QSEC) ? owner_valid : 1'b1)))
    else $error("owner inconsistent with event");

  a_queued: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_QACTIVE || event_res == EV_QSEC ||
                  event_res == EV_WOKE) |-> thread_waiting)
    else $error("queued thread not waiting");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");

endmodule

bind multi_queue_lock_arbiter mqla_chk u_mqla_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .owner_valid    (out_ch.owner_valid),
  .owner_thread   (out_ch.owner_thread),
  .thread_waiting (out_ch.thread_waiting),
  .event_res      (out_ch.event_res)
);

// ===== dv/multi_queue_lock_arbiter_tb.sv =====
module multi_queue_lock_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mqla_pkg::*;

  typedef struct packed {
    logic       owner_valid;
    logic [3:0] owner_thread;
    logic       thread_waiting;
    ev_t        event_res;
  } lock_res_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] tid;
    logic [2:0] cpu;
    logic       typed;
    lock_res_t  res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SLICE_W-1:0] cfg_wdata;

  mqla_in_if  in_ch();
  mqla_out_if out_ch();

  multi_queue_lock_arbiter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [15:0] slice_len;
  logic [15:0] wake_thr;
  logic        own_v;
  logic [3:0]  own_t;
  logic [31:0] ticket_ctr;
  queue_t      ent_q    [MAX_THREADS];
  logic [31:0] ent_tkt  [MAX_THREADS];
  logic [2:0]  ent_cpu  [MAX_THREADS];
  logic [15:0] ent_act  [MAX_THREADS];
  logic [15:0] ent_slp  [MAX_THREADS];
  logic        cpu_av   [CPU_COUNT];
  logic [3:0]  cpu_at   [CPU_COUNT];

  lock_res_t pending_res[$];
  int err_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic int oldest_waiter(queue_t q, bit any_cpu, int c);
    int best;
    logic [31:0] best_age;
    logic [31:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (ent_q[i] == q && (any_cpu || ent_cpu[i] == c)) begin
        age = ticket_ctr - ent_tkt[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic lock_res_t lock_step(op_t op, logic [3:0] tid, logic [2:0] cpu);
    lock_res_t r;
    ev_t ev;
    int w;
    int c;
    bit wake;
    ev = EV_NONE;
    c = ent_cpu[tid];
    case (op)
      OP_LOCK: begin
        if (!own_v) begin
          own_v = 1'b1;
          own_t = tid;
          ev = EV_GRANTED;
        end else if (ent_q[tid] == Q_NONE) begin
          ticket_ctr++;
          ent_tkt[tid] = ticket_ctr;
          ent_cpu[tid] = cpu;
          if (cpu_av[cpu]) begin
            ent_q[tid] = Q_SLEEP;
            ent_act[tid] = '0;
            ent_slp[tid] = slice_len;
            ev = EV_QSEC;
          end else begin
            ent_q[tid] = Q_ACTIVE;
            ent_act[tid] = slice_len;
            ent_slp[tid] = '0;
            cpu_av[cpu] = 1'b1;
            cpu_at[cpu] = tid;
            ev = EV_QACTIVE;
          end
        end
      end
      OP_TICK: begin
        if (ent_q[tid] == Q_ACTIVE) begin
          ent_act[tid] = ent_act[tid] - 16'd1;
          if (ent_act[tid] == '0) begin
            ent_q[tid] = Q_SLEEP;
            ent_slp[tid] = slice_len;
            if (cpu_av[c] && cpu_at[c] == tid) cpu_av[c] = 1'b0;
            ev = EV_SLEPT;
          end
        end else if (ent_q[tid] == Q_SLEEP) begin
          ent_slp[tid] = ent_slp[tid] - 16'd1;
          if (ent_slp[tid] == '0) begin
            wake = !cpu_av[c];
            if (!wake) wake = ent_act[cpu_at[c]] < wake_thr;
            if (wake) begin
              ent_q[tid] = Q_ACTIVE;
              ent_act[tid] = slice_len;
              cpu_av[c] = 1'b1;
              cpu_at[c] = tid;
              ev = EV_WOKE;
            end else begin
              ent_slp[tid] = slice_len;
            end
          end
        end
      end
      OP_UNLOCK: begin
        w = oldest_waiter(Q_ACTIVE, 1'b1, 0);
        if (w >= 0) cpu_av[ent_cpu[w]] = 1'b0;
        else
          for (int k = 0; k < CPU_COUNT && w < 0; k++) w = oldest_waiter(Q_SLEEP, 1'b0, k);
        if (w >= 0) begin
          ent_q[w] = Q_NONE;
          own_v = 1'b1;
          own_t = w[3:0];
          ev = EV_HANDED;
        end else if (own_v) begin
          own_v = 1'b0;
          own_t = '0;
          ev = EV_RELEASED;
        end
      end
      default: ;
    endcase
    r.owner_valid = own_v;
    r.owner_thread = own_v ? own_t : 4'd0;
    r.thread_waiting = (op == OP_UNLOCK) ? (ent_q[tid] != Q_NONE) : (ent_q[tid] != Q_NONE);
    r.event_res = ev;
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    lock_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        report("unexpected item, event", out_ch.event_res, 0);
      end else begin
        e = pending_res.pop_front();
        if (out_ch.owner_valid !== e.owner_valid)
          report("owner_valid", out_ch.owner_valid, e.owner_valid);
        if (out_ch.owner_thread !== e.owner_thread)
          report("owner_thread", out_ch.owner_thread, e.owner_thread);
        if (out_ch.thread_waiting !== e.thread_waiting)
          report("thread_waiting", out_ch.thread_waiting, e.thread_waiting);
        if (out_ch.event_res !== e.event_res)
          report("event_res", out_ch.event_res, e.event_res);
      end
    end
  end

  // receiver side, long hold-off counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      out_ch.ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(op_t op, logic [3:0] tid, logic [2:0] cpu, logic typed, lock_res_t want);
    lock_res_t r;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.thread_id <= tid;
    in_ch.cpu_id <= cpu;
    do @(posedge clk); while (!in_ch.ready);
    r = lock_step(op, tid, cpu);
    pending_res.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (MAX_THREADS + 8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SLICE) slice_len = val;
    else wake_thr = val;
  endtask

  task automatic random_items(int n, bit pause_mid);
    int r;
    op_t op;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk);
      end
      r = $urandom_range(99);
      op = (r < 35) ? OP_LOCK : (r < 75) ? OP_TICK : (r < 90) ? OP_UNLOCK : OP_QUERY;
      send(op, 4'($urandom_range(15)),
           ($urandom_range(9) < 7) ? 3'($urandom_range(3)) : 3'($urandom_range(7)),
           1'b0, '0);
    end
  endtask

  stim_row_t dir_tab [15];

  initial begin
    dir_tab = '{
      '{OP_QUERY,  4'd0,  3'd0, 1'b1, '{1'b0, 4'd0,  1'b0, EV_NONE}},
      '{OP_UNLOCK, 4'd0,  3'd0, 1'b1, '{1'b0, 4'd0,  1'b0, EV_NONE}},
      '{OP_LOCK,   4'd0,  3'd0, 1'b1, '{1'b1, 4'd0,  1'b0, EV_GRANTED}},
      '{OP_LOCK,   4'd15, 3'd7, 1'b1, '{1'b1, 4'd0,  1'b1, EV_QACTIVE}},
      '{OP_LOCK,   4'd1,  3'd7, 1'b1, '{1'b1, 4'd0,  1'b1, EV_QSEC}},
      '{OP_LOCK,   4'd1,  3'd7, 1'b1, '{1'b1, 4'd0,  1'b1, EV_NONE}},
      '{OP_LOCK,   4'd0,  3'd3, 1'b1, '{1'b1, 4'd0,  1'b1, EV_QACTIVE}},
      '{OP_TICK,   4'd2,  3'd5, 1'b1, '{1'b1, 4'd0,  1'b0, EV_NONE}},
      '{OP_TICK,   4'd15, 3'd0, 1'b0, '0},
      '{OP_QUERY,  4'd15, 3'd7, 1'b0, '0},
      '{OP_UNLOCK, 4'd15, 3'd0, 1'b1, '{1'b1, 4'd15, 1'b0, EV_HANDED}},
      '{OP_UNLOCK, 4'd0,  3'd0, 1'b1, '{1'b1, 4'd0,  1'b0, EV_HANDED}},
      '{OP_UNLOCK, 4'd1,  3'd0, 1'b1, '{1'b1, 4'd1,  1'b0, EV_HANDED}},
      '{OP_UNLOCK, 4'd0,  3'd0, 1'b1, '{1'b0, 4'd0,  1'b0, EV_RELEASED}},
      '{OP_UNLOCK, 4'd0,  3'd0, 1'b1, '{1'b0, 4'd0,  1'b0, EV_NONE}}
    };
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_QUERY;
    in_ch.thread_id = '0;
    in_ch.cpu_id = '0;
    slice_len = SLICE_RESET;
    wake_thr = WAKE_RESET;
    own_v = 1'b0;
    own_t = '0;
    ticket_ctr = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      ent_q[i] = Q_NONE;
      ent_tkt[i] = '0;
      ent_cpu[i] = '0;
      ent_act[i] = '0;
      ent_slp[i] = '0;
    end
    for (int i = 0; i < CPU_COUNT; i++) begin
      cpu_av[i] = 1'b0;
      cpu_at[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].tid, dir_tab[i].cpu, dir_tab[i].typed, dir_tab[i].res);
    drain();

    write_reg(CFG_SLICE, 16'd1);
    write_reg(CFG_WAKE, 16'd0);
    random_items(280, 1'b0);
    drain();

    idle_pct = 88;
    write_reg(CFG_WAKE, 16'hffff);
    random_items(260, 1'b0);
    drain();

    idle_pct = 0;
    stall_pct = 88;
    write_reg(CFG_SLICE, 16'd2);
    write_reg(CFG_WAKE, 16'd2);
    random_items(260, 1'b0);
    drain();

    idle_pct = 26;
    stall_pct = 26;
    write_reg(CFG_SLICE, 16'd3);
    random_items(280, 1'b1);
    drain();

    idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_SLICE, 16'hffff);
    write_reg(CFG_WAKE, 16'hffff);
    hold_req = 400;
    random_items(150, 1'b0);
    drain();

    write_reg(CFG_SLICE, 16'd1);
    write_reg(CFG_WAKE, 16'd1);
    random_items(405, 1'b0);
    drain();

    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mqla_pkg.sv
rtl/mqla_if.sv
rtl/mqla_ram.sv
rtl/multi_queue_lock_arbiter.sv
rtl/mqla_chk.sv
dv/multi_queue_lock_arbiter_tb.sv
